@@ hdl/closest_point_on_triangle_macros.svh @@
// assertion helpers for the closest point pipeline
`ifndef CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPT_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("closest point check failed");

// next-cycle implication, disabled during reset
`define CPT_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("closest point check failed");

`endif

@@ hdl/cpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

  // default coordinate format
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // region codes
  typedef enum logic [2:0] {
    RGN_VERT_A  = 3'd0,
    RGN_VERT_B  = 3'd1,
    RGN_EDGE_AB = 3'd2,
    RGN_VERT_C  = 3'd3,
    RGN_EDGE_AC = 3'd4,
    RGN_EDGE_BC = 3'd5,
    RGN_FACE    = 3'd6
  } region_e;

endpackage

`default_nettype wire

@@ hdl/cpt_wmul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpt_wmul #(
  parameter int WIDTH = 68
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WIDTH-1:0]     a_i,
  input  logic signed [WIDTH-1:0]     b_i,
  output logic signed [2*WIDTH-1:0]   p_o
);

  localparam int LO = (WIDTH + 1) / 2;
  localparam int HI = WIDTH - LO;
  localparam int PW = 2 * WIDTH;

  logic signed [LO:0]       al, bl;
  logic signed [HI-1:0]     ah, bh;
  logic signed [2*LO+1:0]   pp_ll_q;
  logic signed [LO+HI:0]    pp_lh_q, pp_hl_q;
  logic signed [2*HI-1:0]   pp_hh_q;
  logic signed [PW-1:0]     p_q;

  // operand halves, low halves as unsigned
  assign al = $signed({1'b0, a_i[LO-1:0]});
  assign bl = $signed({1'b0, b_i[LO-1:0]});
  assign ah = $signed(a_i[WIDTH-1:LO]);
  assign bh = $signed(b_i[WIDTH-1:LO]);

  // partial products, then their weighted sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= al * bl;
      pp_lh_q <= al * bh;
      pp_hl_q <= ah * bl;
      pp_hh_q <= ah * bh;
      p_q     <= (PW'(pp_hh_q) <<< (2 * LO))
               + ((PW'(pp_lh_q) + PW'(pp_hl_q)) <<< LO)
               + PW'(pp_ll_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ hdl/cpt_frac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpt_frac #(
  parameter int NW = 141,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic [FB:0]          t_o
);

  logic [NW-1:0] ra_q, da_q;
  logic          za_q;
  logic [NW-1:0] r_q [FB+1];
  logic [NW-1:0] d_q [FB+1];
  logic [FB-1:0] q_q [FB+1];
  logic          z_q [FB+1];
  logic          o_q [FB+1];
  logic [NW-1:0] r_d [FB];
  logic          b_d [FB];
  logic [NW:0]   rs [FB];

  // one quotient bit per stage, restoring
  always_comb begin
    for (int i = 0; i < FB; i++) begin
      rs[i] = {r_q[i], 1'b0};
      b_d[i] = (rs[i] >= {1'b0, d_q[i]});
      r_d[i] = b_d[i] ? NW'(rs[i] - {1'b0, d_q[i]}) : NW'(rs[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // signs and magnitudes
      za_q <= (num_i == '0) || (den_i == '0) || (num_i[NW-1] != den_i[NW-1]);
      ra_q <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      da_q <= den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
      // fraction at or above one
      r_q[0] <= ra_q;
      d_q[0] <= da_q;
      z_q[0] <= za_q;
      o_q[0] <= (ra_q >= da_q);
      q_q[0] <= '0;
      for (int i = 0; i < FB; i++) begin
        r_q[i+1] <= r_d[i];
        d_q[i+1] <= d_q[i];
        z_q[i+1] <= z_q[i];
        o_q[i+1] <= o_q[i];
        q_q[i+1] <= {q_q[i][FB-2:0], b_d[i]};
      end
    end
  end

  assign t_o = z_q[FB] ? '0 : (o_q[FB] ? {1'b1, {FB{1'b0}}} : {1'b0, q_q[FB]});

endmodule

`default_nettype wire

@@ hdl/closest_point_on_triangle.sv @@
// closest point on a triangle, Voronoi region pipeline
// throughput: one word per cycle while m_axis_tready does not stall the output, set by the fully pipelined datapath
// both barycentric dividers give one quotient bit per stage
// reset: rst_ni async active low clears all stage valid bits, no words in flight
`timescale 1ns / 1ps
`default_nettype none
`include "closest_point_on_triangle_macros.svh"

module closest_point_on_triangle #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DEF,
  localparam int IN_TW  = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // point x,y,z, vert a x,y,z, vert b x,y,z, vert c x,y,z
  input  logic [IN_TW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // closest x, closest y, closest z
  output logic [OUT_TW-1:0] m_axis_tdata,
  // region[2:0], degenerate[3]
  output logic [3:0]        m_axis_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DFW = W + 1;
  localparam int PRW = 2 * DFW;
  localparam int DW  = PRW + 2;
  localparam int XW  = DW + 1;
  localparam int VW  = 2 * DW + 1;
  localparam int NW  = VW + 2;
  localparam int MW  = DFW + F + 2;
  localparam int SW  = W + F + 5;
  localparam int LAT = F + 11;

  typedef struct packed {
    logic [2:0][W-1:0]   a, b, c;
    logic [2:0][DFW-1:0] ab, ac, bc;
  } geo_t;

  typedef struct packed {
    logic [5:0][DW-1:0] d;
    logic [3:0][XW-1:0] x;   // d1-d3, d2-d6, d4-d3, d5-d6
  } dots_t;

  typedef struct packed {
    logic [2:0]          region;
    logic                degen;
    logic                use1;
    logic                use2;
    logic [2:0][W-1:0]   base;
    logic [2:0][DFW-1:0] dir1, dir2;
  } sel_t;

  logic             en;
  logic [LAT-1:0]   v_q;

  // pipeline advance and valid line
  assign en            = !v_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: edge and offset vectors
  geo_t                g1_d;
  logic [2:0][DFW-1:0] ap_d, bp_d, cp_d, ap_q, bp_q, cp_q;
  geo_t                geo_q [6];

  always_comb begin
    logic [W-1:0] p, a, b, c;
    for (int k = 0; k < 3; k++) begin
      p = s_axis_tdata[k*W +: W];
      a = s_axis_tdata[(3+k)*W +: W];
      b = s_axis_tdata[(6+k)*W +: W];
      c = s_axis_tdata[(9+k)*W +: W];
      g1_d.a[k]  = a;
      g1_d.b[k]  = b;
      g1_d.c[k]  = c;
      g1_d.ab[k] = $signed({b[W-1], b}) - $signed({a[W-1], a});
      g1_d.ac[k] = $signed({c[W-1], c}) - $signed({a[W-1], a});
      g1_d.bc[k] = $signed({c[W-1], c}) - $signed({b[W-1], b});
      ap_d[k]    = $signed({p[W-1], p}) - $signed({a[W-1], a});
      bp_d[k]    = $signed({p[W-1], p}) - $signed({b[W-1], b});
      cp_d[k]    = $signed({p[W-1], p}) - $signed({c[W-1], c});
    end
  end

  // stage 2: coordinate products for the six dot products
  logic signed [PRW-1:0] pr_d [6][3];
  logic signed [PRW-1:0] pr_q [6][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_d[0][k] = $signed(geo_q[0].ab[k]) * $signed(ap_q[k]);
      pr_d[1][k] = $signed(geo_q[0].ac[k]) * $signed(ap_q[k]);
      pr_d[2][k] = $signed(geo_q[0].ab[k]) * $signed(bp_q[k]);
      pr_d[3][k] = $signed(geo_q[0].ac[k]) * $signed(bp_q[k]);
      pr_d[4][k] = $signed(geo_q[0].ab[k]) * $signed(cp_q[k]);
      pr_d[5][k] = $signed(geo_q[0].ac[k]) * $signed(cp_q[k]);
    end
  end

  // stage 3: dot sums; stage 4: differences of dots
  dots_t dq_q [4];
  dots_t d3_d, d4_d;

  always_comb begin
    d3_d = '0;
    for (int j = 0; j < 6; j++) begin
      d3_d.d[j] = DW'(pr_q[j][0]) + DW'(pr_q[j][1]) + DW'(pr_q[j][2]);
    end
    d4_d = dq_q[0];
    d4_d.x[0] = $signed(XW'($signed(dq_q[0].d[0]))) - $signed(XW'($signed(dq_q[0].d[2])));
    d4_d.x[1] = $signed(XW'($signed(dq_q[0].d[1]))) - $signed(XW'($signed(dq_q[0].d[5])));
    d4_d.x[2] = $signed(XW'($signed(dq_q[0].d[3]))) - $signed(XW'($signed(dq_q[0].d[2])));
    d4_d.x[3] = $signed(XW'($signed(dq_q[0].d[4]))) - $signed(XW'($signed(dq_q[0].d[5])));
  end

  // stages 4 and 5: cross products of dots
  logic signed [2*DW-1:0] m14, m32, m52, m16, m36, m54;

  cpt_wmul #(.WIDTH(DW)) u_m14 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[0])), .b_i($signed(dq_q[0].d[3])), .p_o(m14));
  cpt_wmul #(.WIDTH(DW)) u_m32 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[2])), .b_i($signed(dq_q[0].d[1])), .p_o(m32));
  cpt_wmul #(.WIDTH(DW)) u_m52 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[4])), .b_i($signed(dq_q[0].d[1])), .p_o(m52));
  cpt_wmul #(.WIDTH(DW)) u_m16 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[0])), .b_i($signed(dq_q[0].d[5])), .p_o(m16));
  cpt_wmul #(.WIDTH(DW)) u_m36 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[2])), .b_i($signed(dq_q[0].d[5])), .p_o(m36));
  cpt_wmul #(.WIDTH(DW)) u_m54 (.clk_i, .en_i(en),
    .a_i($signed(dq_q[0].d[4])), .b_i($signed(dq_q[0].d[3])), .p_o(m54));

  // stage 6: barycentric weights
  logic signed [VW-1:0] va_q, vb_q, vc_q;

  // stage 7: region select
  sel_t                 sel_d, sel_q;
  logic signed [NW-1:0] num0_d, num1_d, den_d, num0_q, num1_q, den_q;

  always_comb begin
    logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [XW-1:0] d13, d26, d43, d56;
    geo_t g;
    d1 = $signed(dq_q[3].d[0]);
    d2 = $signed(dq_q[3].d[1]);
    d3 = $signed(dq_q[3].d[2]);
    d4 = $signed(dq_q[3].d[3]);
    d5 = $signed(dq_q[3].d[4]);
    d6 = $signed(dq_q[3].d[5]);
    d13 = $signed(dq_q[3].x[0]);
    d26 = $signed(dq_q[3].x[1]);
    d43 = $signed(dq_q[3].x[2]);
    d56 = $signed(dq_q[3].x[3]);
    g = geo_q[5];
    sel_d.region = cpt_pkg::RGN_FACE;
    sel_d.degen  = 1'b0;
    sel_d.use1   = 1'b0;
    sel_d.use2   = 1'b0;
    sel_d.base   = g.a;
    sel_d.dir1   = g.ab;
    sel_d.dir2   = g.ac;
    num0_d = NW'(vb_q);
    num1_d = NW'(vc_q);
    den_d  = NW'(va_q) + NW'(vb_q) + NW'(vc_q);
    // regions in priority order
    if ((d1 <= 0) && (d2 <= 0)) begin
      sel_d.region = cpt_pkg::RGN_VERT_A;
    end else if ((d3 >= 0) && (d43 <= 0)) begin
      sel_d.region = cpt_pkg::RGN_VERT_B;
      sel_d.base   = g.b;
    end else if ((vc_q <= 0) && (d1 >= 0) && (d3 <= 0)) begin
      sel_d.region = cpt_pkg::RGN_EDGE_AB;
      sel_d.use1   = 1'b1;
      num0_d = NW'(d1);
      den_d  = NW'(d13);
    end else if ((d6 >= 0) && (d56 <= 0)) begin
      sel_d.region = cpt_pkg::RGN_VERT_C;
      sel_d.base   = g.c;
    end else if ((vb_q <= 0) && (d2 >= 0) && (d6 <= 0)) begin
      sel_d.region = cpt_pkg::RGN_EDGE_AC;
      sel_d.use1   = 1'b1;
      sel_d.dir1   = g.ac;
      num0_d = NW'(d2);
      den_d  = NW'(d26);
    end else if ((va_q <= 0) && (d43 >= 0) && (d56 >= 0)) begin
      sel_d.region = cpt_pkg::RGN_EDGE_BC;
      sel_d.use1   = 1'b1;
      sel_d.base   = g.b;
      sel_d.dir1   = g.bc;
      num0_d = NW'(d43);
      den_d  = NW'(d43) + NW'(d56);
    end else begin
      sel_d.use1 = 1'b1;
      sel_d.use2 = 1'b1;
    end
    // zero denominator falls back to vertex a
    if (sel_d.use1 && (den_d == '0)) begin
      sel_d.region = cpt_pkg::RGN_VERT_A;
      sel_d.degen  = 1'b1;
      sel_d.use1   = 1'b0;
      sel_d.use2   = 1'b0;
      sel_d.base   = g.a;
    end
  end

  // stages 8 on: fractions
  logic [F:0] t0, t1;

  cpt_frac #(.NW(NW), .FB(F)) u_frac0 (.clk_i, .en_i(en),
    .num_i(num0_q), .den_i(den_q), .t_o(t0));
  cpt_frac #(.NW(NW), .FB(F)) u_frac1 (.clk_i, .en_i(en),
    .num_i(num1_q), .den_i(den_q), .t_o(t1));

  sel_t sl_q [F+2];

  // placement products
  logic [F:0]             tm1, tm2;
  logic signed [MW-1:0]   pm1_q [3];
  logic signed [MW-1:0]   pm2_q [3];
  logic [2:0][W-1:0]      pb_q;
  logic [2:0]             pr_rgn_q;
  logic                   pr_dg_q;

  assign tm1 = sl_q[F+1].use1 ? t0 : '0;
  assign tm2 = sl_q[F+1].use2 ? t1 : '0;

  // sum, scale, offset and saturate
  logic [2:0][W-1:0] cl_d, cl_q;
  logic [2:0]        rgn_q;
  logic              dg_q;

  always_comb begin
    logic signed [SW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = ((SW'(pm1_q[k]) + SW'(pm2_q[k])) >>> F) + SW'($signed(pb_q[k]));
      if (s[SW-1:W-1] == '0 || s[SW-1:W-1] == '1) begin
        cl_d[k] = s[W-1:0];
      end else if (s[SW-1]) begin
        cl_d[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        cl_d[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  // data registers, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[0] <= g1_d;
      for (int i = 1; i < 6; i++) geo_q[i] <= geo_q[i-1];
      ap_q <= ap_d;
      bp_q <= bp_d;
      cp_q <= cp_d;
      pr_q <= pr_d;
      dq_q[0] <= d3_d;
      dq_q[1] <= d4_d;
      dq_q[2] <= dq_q[1];
      dq_q[3] <= dq_q[2];
      vc_q <= VW'(m14) - VW'(m32);
      vb_q <= VW'(m52) - VW'(m16);
      va_q <= VW'(m36) - VW'(m54);
      sel_q  <= sel_d;
      num0_q <= num0_d;
      num1_q <= num1_d;
      den_q  <= den_d;
      sl_q[0] <= sel_q;
      for (int i = 1; i < F + 2; i++) sl_q[i] <= sl_q[i-1];
      for (int k = 0; k < 3; k++) begin
        pm1_q[k] <= $signed(sl_q[F+1].dir1[k]) * $signed({1'b0, tm1});
        pm2_q[k] <= $signed(sl_q[F+1].dir2[k]) * $signed({1'b0, tm2});
      end
      pb_q     <= sl_q[F+1].base;
      pr_rgn_q <= sl_q[F+1].region;
      pr_dg_q  <= sl_q[F+1].degen;
      cl_q  <= cl_d;
      rgn_q <= pr_rgn_q;
      dg_q  <= pr_dg_q;
    end
  end

  assign m_axis_tdata = OUT_TW'({cl_q[2], cl_q[1], cl_q[0]});
  assign m_axis_tuser = {dg_q, rgn_q};

  // checks
  `CPT_ASSERT_IMP(a_degen_vert_a, clk_i, rst_ni, m_axis_tvalid && dg_q,
    rgn_q == cpt_pkg::RGN_VERT_A)
  `CPT_ASSERT_IMP(a_degen_no_frac, clk_i, rst_ni, v_q[6] && sel_q.degen,
    !sel_q.use1 && !sel_q.use2)
  `CPT_ASSERT_NXT(a_last_stage_fill, clk_i, rst_ni, v_q[LAT-2] && en, m_axis_tvalid)

endmodule

`default_nettype wire
